@@ rtl/trsi_pkg.sv @@
`timescale 1ns / 1ps
package trsi_pkg;

  localparam int DET_EPS     = 17;
  localparam int INV_SHIFT   = 28;
  localparam int QBITS       = 34;
  localparam int OUT_IDX_W   = 24;
  localparam int INV_W       = 32;
  localparam int AREA_W      = 49;
  localparam int MAT_IN_W    = 32;
  localparam int MAT_W       = 31;
  localparam int OUT_DATA_W  = 280;
  localparam logic [MAT_W-1:0] MAT_DEFAULT = 31'd256000000;
  localparam logic [INV_W-1:0] INV_POS_MAX = 32'h7FFF_FFFF;
  localparam logic [INV_W-1:0] INV_NEG_MIN = 32'h8000_0000;

  function automatic int trsi_entry_w(int iw, int cw);
    return 3 * iw + 4 * (cw + 1) + 1 + (2 * cw + 3) + MAT_W;
  endfunction

endpackage

@@ rtl/trsi_front.sv @@
`timescale 1ns / 1ps
module trsi_front import trsi_pkg::*; #(
  parameter int IW = 24,
  parameter int CW = 24,
  parameter int DATA_W = 248
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [DATA_W-1:0]                  in_data,
  input  logic                               in_present,
  output logic                               q_valid,
  input  logic                               q_ready,
  output logic [trsi_entry_w(IW, CW)-1:0]    q_data
);

  localparam int VW = IW + 2 * CW;
  localparam int PW = 2 * CW + 2;
  localparam int DW = 2 * CW + 3;

  logic                 v1_r, v2_r, v3_r;
  logic                 adv1, adv2, adv3;

  logic [IW-1:0]        idx1_r [3];
  logic signed [CW-1:0] x1_r [3];
  logic signed [CW-1:0] y1_r [3];
  logic [MAT_IN_W-1:0]  mat1_r;
  logic                 pres1_r;

  logic signed [CW:0]   sm [3];
  logic [1:0]           o, f, s;
  logic signed [CW:0]   m00, m10, m01, m11;
  logic [MAT_W-1:0]     mat_c;

  logic [IW-1:0]        io2_r, if2_r, is2_r;
  logic signed [CW:0]   m00_2_r, m10_2_r, m01_2_r, m11_2_r;
  logic [MAT_W-1:0]     mat2_r;

  logic [IW-1:0]        io3_r, if3_r, is3_r;
  logic signed [CW:0]   m00_3_r, m10_3_r, m01_3_r, m11_3_r;
  logic signed [PW-1:0] p0_3_r, p1_3_r;
  logic [MAT_W-1:0]     mat3_r;

  logic signed [DW-1:0] det;
  logic [DW-1:0]        adet, adet_c;

  assign adv3     = !v3_r || q_ready;
  assign adv2     = !v2_r || adv3;
  assign adv1     = !v1_r || adv2;
  assign in_ready = adv1;
  assign q_valid  = v3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (adv1) v1_r <= in_valid;
      if (adv2) v2_r <= v1_r;
      if (adv3) v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv1) begin
      for (int k = 0; k < 3; k++) begin
        idx1_r[k] <= in_data[k*VW +: IW];
        x1_r[k]   <= in_data[k*VW+IW +: CW];
        y1_r[k]   <= in_data[k*VW+IW+CW +: CW];
      end
      mat1_r  <= in_data[3*VW +: MAT_IN_W];
      pres1_r <= in_present;
    end
  end

  // origin pick and edge vectors
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      sm[k] = {x1_r[k][CW-1], x1_r[k]} + {y1_r[k][CW-1], y1_r[k]};
    end
    o = 2'd0;
    for (int k = 1; k < 3; k++) begin
      if (sm[k] < sm[o] || (sm[k] == sm[o] && (y1_r[k] < y1_r[o] ||
          (y1_r[k] == y1_r[o] && x1_r[k] < x1_r[o])))) begin
        o = 2'(k);
      end
    end
    unique case (o)
      2'd0: begin
        f = 2'd1;
        s = 2'd2;
      end
      2'd1: begin
        f = 2'd2;
        s = 2'd0;
      end
      default: begin
        f = 2'd0;
        s = 2'd1;
      end
    endcase
    m00 = {x1_r[f][CW-1], x1_r[f]} - {x1_r[o][CW-1], x1_r[o]};
    m10 = {y1_r[f][CW-1], y1_r[f]} - {y1_r[o][CW-1], y1_r[o]};
    m01 = {x1_r[s][CW-1], x1_r[s]} - {x1_r[o][CW-1], x1_r[o]};
    m11 = {y1_r[s][CW-1], y1_r[s]} - {y1_r[o][CW-1], y1_r[o]};
    if (!pres1_r) begin
      mat_c = '0;
    end else if ($signed(mat1_r) <= 0) begin
      mat_c = MAT_DEFAULT;
    end else begin
      mat_c = mat1_r[MAT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (adv2) begin
      io2_r   <= idx1_r[o];
      if2_r   <= idx1_r[f];
      is2_r   <= idx1_r[s];
      m00_2_r <= m00;
      m10_2_r <= m10;
      m01_2_r <= m01;
      m11_2_r <= m11;
      mat2_r  <= mat_c;
    end
  end

  always_ff @(posedge clk) begin
    if (adv3) begin
      io3_r   <= io2_r;
      if3_r   <= if2_r;
      is3_r   <= is2_r;
      m00_3_r <= m00_2_r;
      m10_3_r <= m10_2_r;
      m01_3_r <= m01_2_r;
      m11_3_r <= m11_2_r;
      p0_3_r  <= m00_2_r * m11_2_r;
      p1_3_r  <= m01_2_r * m10_2_r;
      mat3_r  <= mat2_r;
    end
  end

  // determinant with epsilon clamp
  always_comb begin
    det    = {p0_3_r[PW-1], p0_3_r} - {p1_3_r[PW-1], p1_3_r};
    adet   = det[DW-1] ? DW'(-det) : DW'(det);
    adet_c = (adet < DW'(DET_EPS)) ? DW'(DET_EPS) : adet;
  end

  assign q_data = {mat3_r, adet_c, det[DW-1], m11_3_r, m10_3_r, m01_3_r, m00_3_r,
                   is3_r, if3_r, io3_r};

endmodule

@@ rtl/trsi_queue.sv @@
`timescale 1ns / 1ps
module trsi_queue import trsi_pkg::*; #(
  parameter int W = 8
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         wr_valid,
  output logic         wr_ready,
  input  logic [W-1:0] wr_data,
  output logic         rd_valid,
  input  logic         rd_ready,
  output logic [W-1:0] rd_data
);

  logic [W-1:0] mem_r [4];
  logic [1:0]   wp_r, rp_r;
  logic [2:0]   cnt_r;
  logic         push, pop;

  assign wr_ready = (cnt_r != 3'd4);
  assign rd_valid = (cnt_r != 3'd0);
  assign rd_data  = mem_r[rp_r];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= wp_r + 2'd1;
      if (pop)  rp_r <= rp_r + 2'd1;
      cnt_r <= cnt_r + 3'(push) - 3'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= wr_data;
  end

endmodule

@@ rtl/trsi_back.sv @@
`timescale 1ns / 1ps
module trsi_back import trsi_pkg::*; #(
  parameter int IW = 24,
  parameter int CW = 24
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            q_valid,
  output logic                            q_ready,
  input  logic [trsi_entry_w(IW, CW)-1:0] q_data,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [OUT_DATA_W-1:0]           out_data,
  output logic                            out_sat
);

  localparam int DW = 2 * CW + 3;
  localparam int QB = QBITS;
  localparam int SH = INV_SHIFT + 1;
  localparam int NW = CW + 1 + SH;
  localparam int RW = DW + QB;
  localparam int XW = 3 * IW + MAT_W;

  logic [IW-1:0]      e_io, e_if, e_is;
  logic signed [CW:0] e_m00, e_m10, e_m01, e_m11;
  logic               e_dneg;
  logic [DW-1:0]      e_adet;
  logic [MAT_W-1:0]   e_mat;

  assign {e_mat, e_adet, e_dneg, e_m11, e_m10, e_m01, e_m00, e_is, e_if, e_io} = q_data;

  logic [QB:0]      v_r;
  logic [QB:0]      adv;
  logic             adv_out;
  logic [NW-1:0]    rem_r  [QB+1][4];
  logic [QB-1:0]    quo_r  [QB+1][4];
  logic [3:0]       neg_r  [QB+1];
  logic [3:0]       zero_r [QB+1];
  logic [3:0]       ovf_r  [QB+1];
  logic [DW-1:0]    d_r    [QB+1];
  logic [XW-1:0]    x_r    [QB+1];

  always_comb begin
    adv_out = !out_valid || out_ready;
    adv[QB] = !v_r[QB] || adv_out;
    for (int j = QB - 1; j >= 0; j--) begin
      adv[j] = !v_r[j] || adv[j+1];
    end
  end

  assign q_ready = adv[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (adv[0]) v_r[0] <= q_valid;
      for (int j = 1; j <= QB; j++) begin
        if (adv[j]) v_r[j] <= v_r[j-1];
      end
    end
  end

  // numerators, signs and overflow pre-check
  logic signed [CW:0] num  [4];
  logic [CW:0]        nmag [4];
  logic [NW-1:0]      dvd  [4];
  logic [3:0]         neg0, zero0, ovf0;

  always_comb begin
    num[0] = e_m11;
    num[1] = -e_m01;
    num[2] = -e_m10;
    num[3] = e_m00;
    for (int l = 0; l < 4; l++) begin
      nmag[l]  = num[l][CW] ? (CW+1)'(-num[l]) : (CW+1)'(num[l]);
      dvd[l]   = {nmag[l], {SH{1'b0}}};
      neg0[l]  = num[l][CW] != e_dneg;
      zero0[l] = (nmag[l] == '0);
      ovf0[l]  = RW'(dvd[l]) >= (RW'(e_adet) << QB);
    end
  end

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      for (int l = 0; l < 4; l++) begin
        rem_r[0][l] <= dvd[l];
        quo_r[0][l] <= '0;
      end
      neg_r[0]  <= neg0;
      zero_r[0] <= zero0;
      ovf_r[0]  <= ovf0;
      d_r[0]    <= e_adet;
      x_r[0]    <= {e_mat, e_is, e_if, e_io};
    end
  end

  // one quotient bit per stage, four lanes side by side
  for (genvar j = 1; j <= QB; j++) begin : g_div
    logic [RW-1:0] rx [4];
    logic [RW-1:0] dx;
    logic [RW-1:0] tr [4];
    logic [3:0]    ge;

    always_comb begin
      dx = RW'(d_r[j-1]) << (QB - j);
      for (int l = 0; l < 4; l++) begin
        rx[l] = RW'(rem_r[j-1][l]);
        tr[l] = rx[l] - dx;
        ge[l] = rx[l] >= dx;
      end
    end

    always_ff @(posedge clk) begin
      if (adv[j]) begin
        for (int l = 0; l < 4; l++) begin
          rem_r[j][l] <= ge[l] ? tr[l][NW-1:0] : rem_r[j-1][l];
          quo_r[j][l] <= quo_r[j-1][l] | (ge[l] ? (QB'(1) << (QB - j)) : QB'(0));
        end
        neg_r[j]  <= neg_r[j-1];
        zero_r[j] <= zero_r[j-1];
        ovf_r[j]  <= ovf_r[j-1];
        d_r[j]    <= d_r[j-1];
        x_r[j]    <= x_r[j-1];
      end
    end
  end

  // rounding, saturation and output register
  logic [QB:0]             qp1  [4];
  logic [QB-1:0]           qq   [4];
  logic [INV_W-1:0]        inv  [4];
  logic [3:0]              satl;
  logic [IW+OUT_IDX_W-1:0] ix   [3];
  logic [DW+AREA_W-1:0]    aext;

  logic [INV_W-1:0]        inv_r [4];
  logic [OUT_IDX_W-1:0]    oidx_r [3];
  logic [AREA_W-1:0]       area_r;
  logic [MAT_W-1:0]        mat_r;
  logic                    sat_r;
  logic                    ov_r;

  always_comb begin
    for (int l = 0; l < 4; l++) begin
      qp1[l]  = (QB+1)'(quo_r[QB][l]) + (QB+1)'(1);
      qq[l]   = qp1[l][QB:1];
      satl[l] = 1'b0;
      if (zero_r[QB][l]) begin
        inv[l] = '0;
      end else if (neg_r[QB][l]) begin
        if (ovf_r[QB][l] || qq[l] > QB'(INV_NEG_MIN)) begin
          inv[l]  = INV_NEG_MIN;
          satl[l] = 1'b1;
        end else begin
          inv[l] = INV_W'(-qq[l]);
        end
      end else begin
        if (ovf_r[QB][l] || qq[l] > QB'(INV_POS_MAX)) begin
          inv[l]  = INV_POS_MAX;
          satl[l] = 1'b1;
        end else begin
          inv[l] = qq[l][INV_W-1:0];
        end
      end
    end
    for (int k = 0; k < 3; k++) begin
      ix[k] = (IW+OUT_IDX_W)'(x_r[QB][k*IW +: IW]);
    end
    aext = (DW+AREA_W)'(d_r[QB] >> 1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else if (adv_out) begin
      ov_r <= v_r[QB];
    end
  end

  always_ff @(posedge clk) begin
    if (adv_out) begin
      for (int l = 0; l < 4; l++) inv_r[l] <= inv[l];
      for (int k = 0; k < 3; k++) oidx_r[k] <= ix[k][OUT_IDX_W-1:0];
      area_r <= aext[AREA_W-1:0];
      mat_r  <= x_r[QB][3*IW +: MAT_W];
      sat_r  <= |satl;
    end
  end

  assign out_valid = ov_r;
  assign out_sat   = sat_r;
  assign out_data  = {mat_r, area_r, inv_r[3], inv_r[2], inv_r[1], inv_r[0],
                      oidx_r[2], oidx_r[1], oidx_r[0]};

endmodule

@@ rtl/triangle_rest_shape_inverse_unit.sv @@
`timescale 1ns / 1ps
// throughput: one triangle per cycle unless out_tready stalls the output
// front end: 3 stages (input, origin pick, edge products), determinant, then a 4-entry queue
// back end: 34-stage radix-2 divider, one quotient bit per stage, four lanes side by side
// reset: synchronous active-low rst_n empties all stages and the queue
module triangle_rest_shape_inverse_unit import trsi_pkg::*; #(
  parameter int INDEX_WIDTH = 24,
  parameter int COORD_WIDTH = 24
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_tvalid,
  output logic in_tready,
  // a_index, a_x, a_y, b_index, b_x, b_y, c_index, c_x, c_y, material_in
  input  logic [((3*(INDEX_WIDTH+2*COORD_WIDTH)+MAT_IN_W+7)/8)*8-1:0] in_tdata,
  // material_present
  input  logic in_tuser,
  output logic out_tvalid,
  input  logic out_tready,
  // origin_index, edge1_index, edge2_index, inv_00, inv_01, inv_10, inv_11,
  // half determinant area, material_out
  output logic [OUT_DATA_W-1:0] out_tdata,
  // inverse_saturated
  output logic out_tuser
);

  localparam int IN_W = ((3*(INDEX_WIDTH+2*COORD_WIDTH)+MAT_IN_W+7)/8)*8;
  localparam int EW   = trsi_entry_w(INDEX_WIDTH, COORD_WIDTH);

  logic          fq_valid, fq_ready, qb_valid, qb_ready;
  logic [EW-1:0] fq_data, qb_data;

  trsi_front #(.IW(INDEX_WIDTH), .CW(COORD_WIDTH), .DATA_W(IN_W)) u_front (
    .clk, .rst_n,
    .in_valid(in_tvalid), .in_ready(in_tready), .in_data(in_tdata), .in_present(in_tuser),
    .q_valid(fq_valid), .q_ready(fq_ready), .q_data(fq_data)
  );

  trsi_queue #(.W(EW)) u_queue (
    .clk, .rst_n,
    .wr_valid(fq_valid), .wr_ready(fq_ready), .wr_data(fq_data),
    .rd_valid(qb_valid), .rd_ready(qb_ready), .rd_data(qb_data)
  );

  trsi_back #(.IW(INDEX_WIDTH), .CW(COORD_WIDTH)) u_back (
    .clk, .rst_n,
    .q_valid(qb_valid), .q_ready(qb_ready), .q_data(qb_data),
    .out_valid(out_tvalid), .out_ready(out_tready), .out_data(out_tdata),
    .out_sat(out_tuser)
  );

endmodule

@@ rtl/trsi_checker.sv @@
`timescale 1ns / 1ps
module trsi_checker import trsi_pkg::*; (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  out_tvalid,
  input logic                  out_tready,
  input logic [OUT_DATA_W-1:0] out_tdata,
  input logic                  out_tuser
);

  a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid) else $error("result dropped while stalled");

  a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata)) else $error("result changed while stalled");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid) else $error("result valid straight after reset");

  a_area_floor: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[248:200] >= 49'd8) else $error("area below clamped determinant");

  a_sat_extreme: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |->
      out_tdata[103:72] == INV_POS_MAX || out_tdata[103:72] == INV_NEG_MIN ||
      out_tdata[135:104] == INV_POS_MAX || out_tdata[135:104] == INV_NEG_MIN ||
      out_tdata[167:136] == INV_POS_MAX || out_tdata[167:136] == INV_NEG_MIN ||
      out_tdata[199:168] == INV_POS_MAX || out_tdata[199:168] == INV_NEG_MIN)
    else $error("saturation flag without a saturated entry");

endmodule

bind triangle_rest_shape_inverse_unit trsi_checker u_trsi_checker (
  .clk, .rst_n, .out_tvalid, .out_tready, .out_tdata, .out_tuser
);

@@ test/triangle_rest_shape_inverse_unit_tb.sv @@
`timescale 1ns / 1ps
module triangle_rest_shape_inverse_unit_tb;
  import trsi_pkg::*;

  localparam int IW = 24;
  localparam int CW = 24;
  localparam int IN_W = ((3*(IW+2*CW)+MAT_IN_W+7)/8)*8;
  localparam int N_RANDOM = 400;
  localparam longint CYCLE_LIMIT = 400000;

  typedef struct packed {
    logic [IW-1:0] idx;
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
  } vertex_t;

  typedef struct {
    vertex_t v[3];
    logic signed [MAT_IN_W-1:0] mat;
    logic mat_present;
  } triangle_t;

  typedef struct {
    logic [OUT_IDX_W-1:0] origin;
    logic [OUT_IDX_W-1:0] edge1;
    logic [OUT_IDX_W-1:0] edge2;
    logic [INV_W-1:0] inv[4];
    logic [AREA_W-1:0] area;
    logic [MAT_W-1:0] mat;
    logic sat;
  } rest_shape_t;

  class rest_shape_scoreboard;
    rest_shape_t pending[$];
    int errors;

    function automatic logic [INV_W-1:0] quotient(longint num, longint det, ref logic sat);
      logic neg;
      logic [127:0] n, d, q;
      neg = (num < 0) != (det < 0);
      n = num < 0 ? -num : num;
      d = det < 0 ? -det : det;
      if (n == 0) return '0;
      n = n << INV_SHIFT;
      q = (2 * n + d) / (2 * d);
      if (!neg) begin
        if (q > 128'h7FFF_FFFF) begin
          sat = 1'b1;
          return INV_POS_MAX;
        end
        return q[INV_W-1:0];
      end
      if (q > 128'h8000_0000) begin
        sat = 1'b1;
        return INV_NEG_MIN;
      end
      return INV_W'(-q);
    endfunction

    function automatic bit lower_left(longint cx, longint cy, longint ox, longint oy);
      if (cx + cy != ox + oy) return cx + cy < ox + oy;
      if (cy != oy) return cy < oy;
      return cx < ox;
    endfunction

    function void note_triangle(triangle_t t);
      rest_shape_t r;
      int o, f, s;
      longint m00, m10, m01, m11, det, adet;
      o = 0;
      for (int k = 1; k < 3; k++)
        if (lower_left(t.v[k].x, t.v[k].y, t.v[o].x, t.v[o].y)) o = k;
      f = (o + 1) % 3;
      s = (o + 2) % 3;
      m00 = longint'(t.v[f].x) - longint'(t.v[o].x);
      m10 = longint'(t.v[f].y) - longint'(t.v[o].y);
      m01 = longint'(t.v[s].x) - longint'(t.v[o].x);
      m11 = longint'(t.v[s].y) - longint'(t.v[o].y);
      det = m00 * m11 - m01 * m10;
      adet = det < 0 ? -det : det;
      if (adet < DET_EPS) begin
        det = det < 0 ? -DET_EPS : DET_EPS;
        adet = DET_EPS;
      end
      r.origin = t.v[o].idx;
      r.edge1 = t.v[f].idx;
      r.edge2 = t.v[s].idx;
      r.sat = 1'b0;
      r.inv[0] = quotient(m11, det, r.sat);
      r.inv[1] = quotient(-m01, det, r.sat);
      r.inv[2] = quotient(-m10, det, r.sat);
      r.inv[3] = quotient(m00, det, r.sat);
      r.area = AREA_W'(adet >> 1);
      r.mat = '0;
      if (t.mat_present) r.mat = (t.mat <= 0) ? MAT_DEFAULT : t.mat[MAT_W-1:0];
      pending.insert(pending.size(), r);
    endfunction

    function void check_result(logic [OUT_DATA_W-1:0] data, logic user);
      rest_shape_t e;
      logic [OUT_DATA_W-1:0] want;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result %h", $time, data);
        errors++;
        return;
      end
      e = pending.pop_front();
      want = {e.mat, e.area, e.inv[3], e.inv[2], e.inv[1], e.inv[0],
              e.edge2, e.edge1, e.origin};
      if (data !== want) begin
        $display("%0t: out_tdata expected %h actual %h", $time, want, data);
        errors++;
      end
      if (user !== e.sat) begin
        $display("%0t: out_tuser expected %b actual %b", $time, e.sat, user);
        errors++;
      end
    endfunction
  endclass

  logic clk, rst_n;
  logic in_tvalid, in_tready, in_tuser;
  logic [IN_W-1:0] in_tdata;
  logic out_tvalid, out_tready, out_tuser;
  logic [OUT_DATA_W-1:0] out_tdata;
  longint cycles;
  rest_shape_scoreboard board;
  triangle_t directed[$];

  triangle_rest_shape_inverse_unit #(.INDEX_WIDTH(IW), .COORD_WIDTH(CW)) DUT (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // receiver stall pattern
  initial begin
    int mode;
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      mode = int'((cycles / 300) % 3);
      if (mode == 0) out_tready <= 1'b1;
      else if (mode == 1) out_tready <= ($urandom_range(0, 3) != 0);
      else out_tready <= ($urandom_range(0, 1) != 0);
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (rst_n && out_tvalid && out_tready) board.check_result(out_tdata, out_tuser);
    if (cycles > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  function automatic triangle_t rand_triangle();
    triangle_t t;
    int span;
    span = $urandom_range(0, 3);
    for (int k = 0; k < 3; k++) begin
      t.v[k].idx = IW'($urandom);
      case (span)
        0: begin
          t.v[k].x = CW'($urandom);
          t.v[k].y = CW'($urandom);
        end
        1: begin
          t.v[k].x = CW'($urandom_range(0, 8191) - 4096);
          t.v[k].y = CW'($urandom_range(0, 8191) - 4096);
        end
        2: begin
          t.v[k].x = CW'($urandom_range(0, 15) - 8);
          t.v[k].y = CW'($urandom_range(0, 15) - 8);
        end
        default: begin
          t.v[k].x = CW'($urandom_range(0, 1 << 20) - (1 << 19));
          t.v[k].y = CW'($urandom_range(0, 1 << 20) - (1 << 19));
        end
      endcase
    end
    // repeated vertices make degenerate triangles
    if ($urandom_range(0, 9) == 0) t.v[$urandom_range(1, 2)] = t.v[0];
    t.mat = $urandom;
    t.mat_present = 1'($urandom_range(0, 1));
    return t;
  endfunction

  function automatic triangle_t make_tri(int ax, int ay, int bx, int by, int cx, int cy,
                                         int mat, bit present);
    triangle_t t;
    t.v[0] = '{24'h000001, CW'(ax), CW'(ay)};
    t.v[1] = '{24'hFFFFFF, CW'(bx), CW'(by)};
    t.v[2] = '{24'h800000, CW'(cx), CW'(cy)};
    t.mat = mat;
    t.mat_present = present;
    return t;
  endfunction

  function automatic void add_directed(triangle_t t);
    directed.insert(directed.size(), t);
  endfunction

  task automatic send_triangle(triangle_t t);
    in_tdata <= {t.mat, t.v[2].y, t.v[2].x, t.v[2].idx, t.v[1].y, t.v[1].x, t.v[1].idx,
                 t.v[0].y, t.v[0].x, t.v[0].idx};
    in_tuser <= t.mat_present;
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    board.note_triangle(t);
    @(negedge clk);
  endtask

  task automatic pause_sender(int n);
    if (n > 0) begin
      in_tvalid <= 1'b0;
      repeat (n) @(negedge clk);
    end
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    do @(negedge clk); while (board.pending.size() != 0);
  endtask

  initial begin
    int left, burst;
    board = new();
    cycles = 0;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = 1'b0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    add_directed(make_tri(0, 0, 4096, 0, 0, 4096, 256, 1));
    add_directed(make_tri(0, 0, 0, 4096, 4096, 0, 0, 1));
    add_directed(make_tri(0, 0, 0, 0, 0, 0, -5, 1));
    add_directed(make_tri(0, 0, 1, 0, 0, 1, 32'h7FFF_FFFF, 1));
    add_directed(make_tri(0, 0, 3, 0, 0, -3, 32'h8000_0000, 1));
    add_directed(make_tri(0, 0, 5, 0, 0, 3, 100, 0));
    add_directed(make_tri(0, 0, 4, 0, 0, -4, 7, 1));
    add_directed(make_tri(-8388608, -8388608, 8388607, -8388608, -8388608, 8388607, 1, 1));
    add_directed(make_tri(8388607, 8388607, -8388608, 8388607, 8388607, -8388608, 1, 0));
    add_directed(make_tri(-8388608, 8388607, 8388607, -8388608, 0, 0, 9, 1));
    add_directed(make_tri(10, 0, 0, 10, 20, 20, 9, 1));
    add_directed(make_tri(5, 5, 5, 5, 5, 5, -1, 0));
    add_directed(make_tri(100, -100, -100, 100, 300, 300, 3, 1));
    add_directed(make_tri(0, 0, 1, 1, 2, 2, 3, 1));
    add_directed(make_tri(-4096, -4096, 4096, -4096, 0, 8192, 1000, 1));
    foreach (directed[i]) send_triangle(directed[i]);
    drain();

    left = N_RANDOM;
    while (left > 0) begin
      burst = $urandom_range(1, 30);
      while (burst > 0 && left > 0) begin
        send_triangle(rand_triangle());
        burst--;
        left--;
      end
      if (left == N_RANDOM / 2) drain();
      else pause_sender($urandom_range(0, 6));
    end
    drain();
    repeat (60) @(negedge clk);
    if (board.errors == 0 && board.pending.size() == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end
endmodule
